@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, quiet while reset is applied
`define ARPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked property that is also checked while reset is applied
`define ARPC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants of the ARP cache table.
// ----------------------------------------------------------------------------
package arpc_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int IP_W        = 32;
	localparam int MAC_W       = 48;
	localparam int SEC_W       = 32;
	localparam int TMO_W       = 16;

	localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd15;

	// operation codes; the fourth code is unused and does nothing
	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	// one table entry as kept in the store
	typedef struct packed {
		logic [IP_W-1:0]  ip;
		logic [MAC_W-1:0] mac;
		logic [SEC_W-1:0] stamp;
	} entry_t;

	// compare unit verdict on one entry
	typedef struct packed {
		logic ip_eq;
		logic aged;
	} cmp_res_t;

endpackage

@@ hdl/arpc_store.sv @@
// ----------------------------------------------------------------------------
// arpc_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arpc_store
	import arpc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data
);

	entry_t mem_q [ENTRIES];
	entry_t rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, registered: data follows the address in the next cycle
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ hdl/arpc_cmp.sv @@
// ----------------------------------------------------------------------------
// arpc_cmp
// Shared compare unit: address match and age check for one entry.
// ----------------------------------------------------------------------------
module arpc_cmp
	import arpc_pkg::*;
(
	input  entry_t           entry,
	input  logic [IP_W-1:0]  key_ip,
	input  logic [SEC_W-1:0] now,
	input  logic [TMO_W-1:0] timeout,
	output cmp_res_t         res
);

	logic [SEC_W-1:0] age;

	// age wraps modulo 2^32
	assign age       = now - entry.stamp;
	assign res.ip_eq = (entry.ip == key_ip);
	assign res.aged  = (age > {{(SEC_W-TMO_W){1'b0}}, timeout});

endmodule

@@ hdl/arp_cache_table_core.sv @@
// ----------------------------------------------------------------------------
// arp_cache_table_core
// IPv4-to-MAC cache with aging: lookup, insert into the first free slot,
// and a one-second tick that expires old entries. Entries are scanned one
// per cycle through a shared compare unit.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-----------------------------------
//  command   | start / busy           | opcode, ip_addr, mac_addr
//  result    | done (1-cycle strobe)  | hit, mac_out, inserted
//  config    | timeout_wr_en          | timeout_wr_data
//
//  Lookup and tick scan every entry, then go through a drain state to the
//  result: one memory read per entry, the drain state to check the last
//  read, the result state to present. Insert stops at the first free slot.
//  An unused opcode goes from accept straight to an all-zero result.
//  Reset clears all valid bits at once; the second counter starts at zero.
//  Results cannot be held off; busy stays high up to and including done.
// ----------------------------------------------------------------------------
module arp_cache_table_core
	import arpc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       opcode,
	input  logic [IP_W-1:0]  ip_addr,
	input  logic [MAC_W-1:0] mac_addr,
	input  logic             timeout_wr_en,
	input  logic [TMO_W-1:0] timeout_wr_data,
	output logic             done,
	output logic             hit,
	output logic [MAC_W-1:0] mac_out,
	output logic             inserted
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_RESP  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [ENTRIES-1:0] valid_q;
	logic [SEC_W-1:0]  now_q;
	logic [TMO_W-1:0]  timeout_q;
	logic              chk_vld_q;
	logic [IDX_W-1:0]  chk_idx_q;
	logic [IDX_W-1:0]  addr_q;
	logic [1:0]        op_q;
	logic [IP_W-1:0]   ip_q;
	logic [MAC_W-1:0]  mac_in_q;
	logic              hit_q;
	logic [MAC_W-1:0]  mac_res_q;
	logic              ins_q;

	logic              accept;
	logic              is_insert;
	logic              scan_rd;
	logic              slot_free;
	logic              wr_en;
	logic              chk_valid;
	entry_t            wr_entry;
	entry_t            rd_entry;
	cmp_res_t          cmp_res;

	assign accept    = start && (state_q == ST_IDLE);
	assign is_insert = (op_q == OP_INSERT);
	assign scan_rd   = (state_q == ST_SCAN) && !is_insert;
	assign slot_free = !valid_q[addr_q];
	assign wr_en     = (state_q == ST_SCAN) && is_insert && slot_free;
	assign chk_valid = chk_vld_q && valid_q[chk_idx_q];

	assign wr_entry.ip    = ip_q;
	assign wr_entry.mac   = mac_in_q;
	assign wr_entry.stamp = now_q;

	arpc_store #(
		.ENTRIES (ENTRIES),
		.IDX_W   (IDX_W)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (wr_entry),
		.rd_addr (addr_q),
		.rd_data (rd_entry)
	);

	arpc_cmp u_cmp (
		.entry   (rd_entry),
		.key_ip  (ip_q),
		.now     (now_q),
		.timeout (timeout_q),
		.res     (cmp_res)
	);

	// sequencer, valid bits, second counter, timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			now_q     <= '0;
			timeout_q <= TIMEOUT_RST;
			chk_vld_q <= 1'b0;
		end else begin
			if (timeout_wr_en) begin
				timeout_q <= timeout_wr_data;
			end
			chk_vld_q <= scan_rd;
			// expire an entry checked during a tick
			if (chk_valid && (op_q == OP_TICK) && cmp_res.aged) begin
				valid_q[chk_idx_q] <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if ((opcode == OP_LOOKUP) || (opcode == OP_INSERT) ||
						    (opcode == OP_TICK)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESP;
						end
						if (opcode == OP_TICK) begin
							now_q <= now_q + SEC_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (is_insert) begin
						if (slot_free) begin
							valid_q[addr_q] <= 1'b1;
							state_q         <= ST_RESP;
						end else if (addr_q == LAST) begin
							state_q <= ST_RESP;
						end
					end else if (addr_q == LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command capture, scan pointer and result registers
	always_ff @(posedge clk) begin
		chk_idx_q <= addr_q;
		if (accept) begin
			op_q      <= opcode;
			ip_q      <= ip_addr;
			mac_in_q  <= mac_addr;
			addr_q    <= '0;
			hit_q     <= 1'b0;
			mac_res_q <= '0;
			ins_q     <= 1'b0;
		end else begin
			if ((state_q == ST_SCAN) && (addr_q != LAST)) begin
				addr_q <= addr_q + IDX_W'(1);
			end
			if (wr_en) begin
				ins_q <= 1'b1;
			end
			// later matches overwrite earlier ones: highest index wins
			if (chk_valid && (op_q == OP_LOOKUP) && cmp_res.ip_eq) begin
				hit_q     <= 1'b1;
				mac_res_q <= rd_entry.mac;
			end
		end
	end

	// result beat
	assign busy     = (state_q != ST_IDLE);
	assign done     = (state_q == ST_RESP);
	assign hit      = done & hit_q;
	assign mac_out  = done ? mac_res_q : '0;
	assign inserted = done & ins_q;

endmodule

@@ hdl/arpc_checker.sv @@
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks on the ARP cache table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arpc_checker
	import arpc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic             hit,
	input logic [MAC_W-1:0] mac_out,
	input logic             inserted
);

	// an accepted command keeps the block busy until its result
	`ARPC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accept did not raise busy")

	// the result beat is a single-cycle strobe
	`ARPC_ASSERT(a_done_pulse, done |=> !done, "done held longer than one cycle")

	// result ports are quiet outside the result beat
	`ARPC_ASSERT(a_quiet, !done |-> (!hit && !inserted && (mac_out == '0)),
		"result ports active without done")

	// a lookup hit and an insert never share a beat; a MAC implies a hit
	`ARPC_ASSERT(a_excl, !(hit && inserted) && ((mac_out != '0) ? hit : 1'b1),
		"inconsistent result fields")

endmodule

bind arp_cache_table_core arpc_checker u_arpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.hit      (hit),
	.mac_out  (mac_out),
	.inserted (inserted)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the ARP cache table core against its own table predictor: lookups,
// inserts into the first free slot, the one-second aging tick and the unused
// opcode, under several timeout settings and with random gaps on the
// command side. Each result beat is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
	import arpc_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int         N_SLOTS   = ENTRIES_DEF;
	localparam int         STALL_MAX = 4000;

	// one result beat
	typedef struct packed {
		logic             hit;
		logic [MAC_W-1:0] mac;
		logic             inserted;
	} arp_reply_t;

	logic             clk = 1'b1;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [1:0]       opcode = OP_LOOKUP;
	logic [IP_W-1:0]  ip_addr = '0;
	logic [MAC_W-1:0] mac_addr = '0;
	logic             timeout_wr_en = 1'b0;
	logic [TMO_W-1:0] timeout_wr_data = '0;
	logic             done;
	logic             hit;
	logic [MAC_W-1:0] mac_out;
	logic             inserted;

	// predicted table contents
	logic             tbl_valid [N_SLOTS];
	logic [IP_W-1:0]  tbl_ip    [N_SLOTS];
	logic [MAC_W-1:0] tbl_mac   [N_SLOTS];
	logic [SEC_W-1:0] tbl_stamp [N_SLOTS];
	logic [SEC_W-1:0] now_sec = '0;
	logic [TMO_W-1:0] tmo_sec = TIMEOUT_RST;

	arp_reply_t      replies_due[$];
	logic [IP_W-1:0] known_ips[$];
	int              error_count = 0;
	int              sender_idle_pct = 0;
	int              stall_cycles = 0;

	arp_cache_table_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.ip_addr         (ip_addr),
		.mac_addr        (mac_addr),
		.timeout_wr_en   (timeout_wr_en),
		.timeout_wr_data (timeout_wr_data),
		.done            (done),
		.hit             (hit),
		.mac_out         (mac_out),
		.inserted        (inserted)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	initial begin
		for (int k = 0; k < N_SLOTS; k++) begin
			tbl_valid[k] = 1'b0;
			tbl_ip[k]    = '0;
			tbl_mac[k]   = '0;
			tbl_stamp[k] = '0;
		end
	end

	// table predictor: applies one command and returns the beat it yields
	function automatic arp_reply_t predict_reply(input logic [1:0] op,
			input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
		arp_reply_t r;
		logic [SEC_W-1:0] age;
		r = '0;
		case (op)
		OP_LOOKUP: begin
			for (int k = 0; k < N_SLOTS; k++)
				if (tbl_valid[k] && tbl_ip[k] == ip) begin
					r.hit = 1'b1;
					r.mac = tbl_mac[k];
				end
		end
		OP_INSERT: begin
			for (int k = 0; k < N_SLOTS; k++)
				if (!r.inserted && !tbl_valid[k]) begin
					tbl_ip[k]    = ip;
					tbl_mac[k]   = mac;
					tbl_stamp[k] = now_sec;
					tbl_valid[k] = 1'b1;
					r.inserted   = 1'b1;
				end
		end
		OP_TICK: begin
			now_sec = now_sec + 1'b1;
			for (int k = 0; k < N_SLOTS; k++) begin
				age = now_sec - tbl_stamp[k];
				if (tbl_valid[k] && age > {16'd0, tmo_sec})
					tbl_valid[k] = 1'b0;
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	// result check, command capture and stall watchdog, all on the rising edge
	always @(posedge clk) begin : monitor
		arp_reply_t want;
		logic took;
		took = 1'b0;
		if (arst_n) begin
			if (done === 1'b1) begin
				took = 1'b1;
				if (replies_due.size() == 0) begin
					$error("result beat with no command outstanding");
					error_count++;
				end else begin
					want = replies_due.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						error_count++;
					end
					if (mac_out !== want.mac) begin
						$error("mac_out: expected %h, got %h", want.mac, mac_out);
						error_count++;
					end
					if (inserted !== want.inserted) begin
						$error("inserted: expected %0d, got %0d", want.inserted, inserted);
						error_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				took = 1'b1;
				replies_due.push_back(predict_reply(opcode, ip_addr, mac_addr));
			end
			if (timeout_wr_en)
				tmo_sec = timeout_wr_data;
			stall_cycles = took ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_MAX) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic logic [MAC_W-1:0] rand_mac();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MAC_W-1:0];
	endfunction

	// sends one command beat; called and returns at a falling edge
	task automatic send_cmd(input logic [1:0] op, input logic [IP_W-1:0] ip,
			input logic [MAC_W-1:0] mac);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start    <= 1'b1;
		opcode   <= op;
		ip_addr  <= ip;
		mac_addr <= mac;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	// holds commands off until every result is back and the core is idle
	task automatic wait_drain();
		start <= 1'b0;
		while (replies_due.size() != 0 || busy !== 1'b0)
			@(negedge clk);
	endtask

	task automatic set_timeout(input logic [TMO_W-1:0] value);
		wait_drain();
		timeout_wr_en   <= 1'b1;
		timeout_wr_data <= value;
		@(negedge clk);
		timeout_wr_en <= 1'b0;
	endtask

	// fresh table: miss, unused opcode, first tick
	task automatic test_empty_table();
		send_cmd(OP_LOOKUP, $urandom, rand_mac());
		send_cmd(OP_UNUSED, '1, '1);
		send_cmd(OP_TICK, $urandom, rand_mac());
	endtask

	// all-zero and all-one addresses
	task automatic test_field_extremes();
		send_cmd(OP_INSERT, '0, '0);
		send_cmd(OP_INSERT, '1, '1);
		send_cmd(OP_LOOKUP, '0, '1);
		send_cmd(OP_LOOKUP, '1, '0);
		send_cmd(OP_LOOKUP, 32'h1234_5678, '0);
	endtask

	// same IP twice: lookup must return the later slot
	task automatic test_duplicate_ip();
		logic [IP_W-1:0] ip;
		ip = $urandom;
		send_cmd(OP_INSERT, ip, rand_mac());
		send_cmd(OP_INSERT, ip, rand_mac());
		send_cmd(OP_LOOKUP, ip, '0);
	endtask

	// expiry with a short timeout, then with zero timeout
	task automatic test_aging();
		logic [IP_W-1:0] ip;
		ip = $urandom;
		set_timeout(16'd2);
		repeat (3) send_cmd(OP_TICK, '0, '0);
		send_cmd(OP_LOOKUP, '0, '0);
		set_timeout(16'd0);
		send_cmd(OP_INSERT, ip, rand_mac());
		send_cmd(OP_LOOKUP, ip, '0);
		send_cmd(OP_TICK, '0, '0);
		send_cmd(OP_LOOKUP, ip, '0);
	endtask

	// fill every slot, then one insert too many
	task automatic test_table_full();
		logic [IP_W-1:0] ip;
		set_timeout('1);
		for (int k = 0; k <= N_SLOTS; k++) begin
			ip = $urandom;
			send_cmd(OP_INSERT, ip, rand_mac());
		end
		send_cmd(OP_LOOKUP, ip, '0);
	endtask

	// random mix; lookups and some inserts reuse recently inserted IPs
	task automatic run_traffic(input int n_items, input logic [TMO_W-1:0] tmo,
			input int idle_pct);
		int pick;
		logic [IP_W-1:0] ip;
		set_timeout(tmo);
		sender_idle_pct = idle_pct;
		for (int n = 0; n < n_items; n++) begin
			pick = $urandom_range(99);
			ip = $urandom;
			if (known_ips.size() != 0 && $urandom_range(99) < 70)
				ip = known_ips[$urandom_range(known_ips.size() - 1)];
			if (pick < 30) begin
				send_cmd(OP_INSERT, ip, rand_mac());
				known_ips.push_back(ip);
				if (known_ips.size() > 48)
					void'(known_ips.pop_front());
			end else if (pick < 75)
				send_cmd(OP_LOOKUP, ip, rand_mac());
			else if (pick < 95)
				send_cmd(OP_TICK, ip, rand_mac());
			else
				send_cmd(OP_UNUSED, ip, rand_mac());
			if ($urandom_range(99) == 0)
				wait_drain();
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_table();
		test_field_extremes();
		test_duplicate_ip();
		test_aging();
		test_table_full();
		run_traffic(540, 16'($urandom_range(20, 40)), 33);
		run_traffic(540, '1, 63);
		run_traffic(300, 16'd1, 0);
		run_traffic(300, 16'($urandom_range(2, 12)), 0);
		wait_drain();
		repeat (N_SLOTS + 8) @(negedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
